FILE: design/running_mean_stddev_stats_core_macros.svh
// Assertion macros for the running statistics core.
`ifndef RUNNING_MEAN_STDDEV_STATS_CORE_MACROS_SVH
`define RUNNING_MEAN_STDDEV_STATS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RMSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmss assertion failed");
`define RMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmss assertion failed");
`else
`define RMSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/rmss_pkg.sv
// Widths and constants of the running statistics core.
`timescale 1ns / 1ps
package rmss_pkg;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 32;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W    = 24;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = 2 * MEAN_W;
  localparam int VAR_W     = ACC_W - FRAC_BITS;
  localparam int ROOT_W    = VAR_W / 2;
  localparam int OUT_W     = COUNT_W + 4 * SAMPLE_W;
  localparam logic [FRAC_BITS-1:0] ROUND_HALF = 8'd128;
endpackage

FILE: design/running_mean_stddev_stats_core.sv
// Running count, min, max, Welford mean and standard deviation of a sample stream.
`timescale 1ns / 1ps
`include "running_mean_stddev_stats_core_macros.svh"

// One input item is one unsigned 16-bit sample; one result item follows each
// sample. A bit-serial restoring divider (one quotient bit per cycle) runs 24
// steps for the mean update and 64 steps for the variance, and a bit-serial
// square root takes 28 steps (two radicand bits per cycle); the steps ST_MEAN,
// ST_MUL, ST_ACC, ST_VAR and ST_RND sit between them. The first sample and a
// saturated count skip the mean division. The next sample is taken once the
// previous result has been placed in the output register.
module running_mean_stddev_stats_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // count, min_seen, max_seen, mean_rounded, std_dev
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_M, ST_MEAN, ST_MUL, ST_ACC, ST_VAR, ST_DIV_V, ST_RND, ST_SQRT, ST_DONE
  } state_e;

  localparam int SW = rmss_pkg::SAMPLE_W;
  localparam int CW = rmss_pkg::COUNT_W;
  localparam int MW = rmss_pkg::MEAN_W;
  localparam int AW = rmss_pkg::ACC_W;
  localparam int FB = rmss_pkg::FRAC_BITS;
  localparam int VW = rmss_pkg::VAR_W;
  localparam int RW = rmss_pkg::ROOT_W;

  state_e                   state_q;
  logic [CW-1:0]            cnt_q;
  logic [SW-1:0]            min_q, max_q, samp_q;
  logic [MW-1:0]            mean_q, d1_q, d2_q;
  logic                     up_q;
  logic [AW-1:0]            sqsum_q;
  logic [rmss_pkg::PROD_W-1:0] prod_q;
  logic [AW-1:0]            dq_q;
  logic [CW-1:0]            rem_q, div_q;
  logic [5:0]               it_q;
  logic [VW-1:0]            sqv_q;
  logic [CW-1:0]            srem_q;
  logic [RW-1:0]            root_q;
  logic                     m_valid_q;
  logic [rmss_pkg::OUT_W-1:0] m_data_q;

  logic          s_hs;
  logic [MW-1:0] s_fix, samp_fix;
  logic          up_in;
  logic [MW-1:0] d1_in;
  logic [CW:0]   rem_sh, rem_diff;
  logic          div_ge;
  logic [MW-1:0] mean_nx, d2_nx;
  logic [AW:0]   acc_sum, rnd_sum;
  logic [AW-1:0] acc_sat, rnd_sat;
  logic [CW-1:0] srem_sh, trial;
  logic          sq_ge;
  logic [MW:0]   mean_rnd;
  logic [SW-1:0] std_val;

  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    s_fix    = {s_axis_tdata, {FB{1'b0}}};
    samp_fix = {samp_q, {FB{1'b0}}};
    up_in    = (s_fix >= mean_q);
    d1_in    = up_in ? (s_fix - mean_q) : (mean_q - s_fix);
    // restoring divider step
    rem_sh   = {rem_q, dq_q[AW-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    div_ge   = !rem_diff[CW];
    mean_nx  = up_q ? (mean_q + dq_q[MW-1:0]) : (mean_q - dq_q[MW-1:0]);
    d2_nx    = up_q ? (samp_fix - mean_nx) : (mean_nx - samp_fix);
    acc_sum  = {1'b0, sqsum_q} + {{(AW+1-(rmss_pkg::PROD_W-FB)){1'b0}},
                                  prod_q[rmss_pkg::PROD_W-1:FB]};
    acc_sat  = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
    rnd_sum  = {1'b0, dq_q} + {{(AW+1-FB){1'b0}}, rmss_pkg::ROUND_HALF};
    rnd_sat  = rnd_sum[AW] ? {AW{1'b1}} : rnd_sum[AW-1:0];
    // square root step: two radicand bits in, one root bit out
    srem_sh  = {srem_q[CW-3:0], sqv_q[VW-1:VW-2]};
    trial    = {{(CW-RW-2){1'b0}}, root_q, 2'b01};
    sq_ge    = (srem_sh >= trial);
    mean_rnd = {1'b0, mean_q} + {{(MW+1-FB){1'b0}}, rmss_pkg::ROUND_HALF};
    std_val  = (root_q[RW-1:SW] != '0) ? {SW{1'b1}} : root_q[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      min_q     <= '0;
      max_q     <= '0;
      samp_q    <= '0;
      mean_q    <= '0;
      d1_q      <= '0;
      d2_q      <= '0;
      up_q      <= 1'b0;
      sqsum_q   <= '0;
      prod_q    <= '0;
      dq_q      <= '0;
      rem_q     <= '0;
      div_q     <= '0;
      it_q      <= '0;
      sqv_q     <= '0;
      srem_q    <= '0;
      root_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // ST_DONE handles the output register itself
      if (m_axis_tready && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            samp_q <= s_axis_tdata;
            if (cnt_q == '0) begin
              cnt_q   <= {{(CW-1){1'b0}}, 1'b1};
              min_q   <= s_axis_tdata;
              max_q   <= s_axis_tdata;
              mean_q  <= s_fix;
              state_q <= ST_VAR;
            end else begin
              if (s_axis_tdata < min_q) min_q <= s_axis_tdata;
              if (s_axis_tdata > max_q) max_q <= s_axis_tdata;
              if (cnt_q != {CW{1'b1}}) begin
                up_q    <= up_in;
                d1_q    <= d1_in;
                dq_q    <= {d1_in, {(AW-MW){1'b0}}};
                rem_q   <= '0;
                div_q   <= cnt_q + 1'b1;
                it_q    <= 6'(MW - 1);
                state_q <= ST_DIV_M;
              end else begin
                state_q <= ST_VAR;
              end
            end
          end
        end
        ST_DIV_M: begin
          rem_q <= div_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
          dq_q  <= {dq_q[AW-2:0], div_ge};
          it_q  <= it_q - 1'b1;
          if (it_q == '0) state_q <= ST_MEAN;
        end
        ST_MEAN: begin
          mean_q  <= mean_nx;
          d2_q    <= d2_nx;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= d1_q * d2_q;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          sqsum_q <= acc_sat;
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          if (cnt_q < CW'(2)) begin
            root_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            dq_q    <= sqsum_q;
            rem_q   <= '0;
            div_q   <= cnt_q - 1'b1;
            it_q    <= 6'(AW - 1);
            state_q <= ST_DIV_V;
          end
        end
        ST_DIV_V: begin
          rem_q <= div_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
          dq_q  <= {dq_q[AW-2:0], div_ge};
          it_q  <= it_q - 1'b1;
          if (it_q == '0) state_q <= ST_RND;
        end
        ST_RND: begin
          sqv_q   <= rnd_sat[AW-1:FB];
          srem_q  <= '0;
          root_q  <= '0;
          it_q    <= 6'(RW - 1);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          srem_q <= sq_ge ? (srem_sh - trial) : srem_sh;
          root_q <= {root_q[RW-2:0], sq_ge};
          sqv_q  <= {sqv_q[VW-3:0], 2'b00};
          it_q   <= it_q - 1'b1;
          if (it_q == '0) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {std_val, mean_rnd[MW-1:FB], max_q, min_q, cnt_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `RMSS_ASSERT_NEXT(a_cnt_sticky, clk_i, rst_ni, cnt_q != '0, cnt_q != '0)
  `RMSS_ASSERT_IMPLIES(a_min_le_max, clk_i, rst_ni, cnt_q != '0, min_q <= max_q)
  `RMSS_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_hs, state_q != ST_IDLE)
  `RMSS_ASSERT_IMPLIES(a_result_has_count, clk_i, rst_ni, $rose(m_valid_q), cnt_q != '0)

endmodule

FILE: tb/tb_running_mean_stddev_stats_core.sv
// Self-checking testbench for the running mean and standard deviation core.
`timescale 1ns / 1ps

module tb_running_mean_stddev_stats_core;
  import rmss_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] std_dev;
    logic [SAMPLE_W-1:0] mean_rounded;
    logic [SAMPLE_W-1:0] max_seen;
    logic [SAMPLE_W-1:0] min_seen;
    logic [COUNT_W-1:0]  count;
  } stats_t;

  class stats_scoreboard;
    logic [COUNT_W-1:0]  n_samples;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [MEAN_W-1:0]   mean_q8;
    logic [ACC_W-1:0]    dev_sq_acc;
    stats_t              pending_stats[$];
    int                  mismatches;

    function new();
      n_samples  = '0;
      lo         = '0;
      hi         = '0;
      mean_q8    = '0;
      dev_sq_acc = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] b;
      root = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    endfunction

    // Folds one sample into the running state and queues the result it should produce.
    function void note_sample(logic [SAMPLE_W-1:0] s);
      logic [31:0] s_fix, d1, d2, stp, n1, root;
      logic [63:0] term, var_q8;
      logic        up;
      stats_t      r;
      s_fix = {8'd0, s, 8'd0};
      if (n_samples == 0) begin
        n_samples = 1;
        lo = s;
        hi = s;
        mean_q8 = s_fix[MEAN_W-1:0];
      end else begin
        if (s < lo) lo = s;
        if (s > hi) hi = s;
        if (n_samples != '1) begin
          n1 = n_samples + 1;
          up = s_fix >= {8'd0, mean_q8};
          d1 = up ? s_fix - mean_q8 : mean_q8 - s_fix;
          stp = d1 / n1;
          mean_q8 = up ? mean_q8 + stp[MEAN_W-1:0] : mean_q8 - stp[MEAN_W-1:0];
          d2 = up ? s_fix - mean_q8 : mean_q8 - s_fix;
          term = (64'(d1) * 64'(d2)) >> FRAC_BITS;
          if (64'hFFFF_FFFF_FFFF_FFFF - dev_sq_acc < term) dev_sq_acc = '1;
          else dev_sq_acc = dev_sq_acc + term;
          n_samples = n1;
        end
      end
      r.count = n_samples;
      r.min_seen = lo;
      r.max_seen = hi;
      r.mean_rounded = 16'((32'(mean_q8) + 32'(ROUND_HALF)) >> FRAC_BITS);
      r.std_dev = '0;
      if (n_samples > 1) begin
        var_q8 = dev_sq_acc / 64'(n_samples - 1);
        if (var_q8 > 64'hFFFF_FFFF_FFFF_FFFF - 64'(ROUND_HALF)) var_q8 = '1;
        else var_q8 = var_q8 + 64'(ROUND_HALF);
        root = int_sqrt(var_q8 >> FRAC_BITS);
        r.std_dev = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
      end
      pending_stats.push_back(r);
    endfunction

    function void check_result(stats_t got);
      stats_t exp_r;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      exp_r = pending_stats.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: count %0d/%0d min %0d/%0d max %0d/%0d mean %0d/%0d sd %0d/%0d",
                   exp_r.count, got.count, exp_r.min_seen, got.min_seen,
                   exp_r.max_seen, got.max_seen, exp_r.mean_rounded, got.mean_rounded,
                   exp_r.std_dev, got.std_dev);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;

  stats_scoreboard sb;
  bit              hold_off_req;

  running_mean_stddev_stats_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offers one sample and holds it until accepted; returns at the next falling edge.
  task automatic send_sample(logic [15:0] s);
    s_axis_tdata  = s;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [15:0] random_sample(int mode, logic [15:0] center);
    case (mode)
      0: return 16'($urandom);
      1: return center + 16'($urandom_range(0, 15)) - 16'd8;
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3: return center;
      default: return center + 16'($urandom_range(0, 1023)) - 16'd512;
    endcase
  endfunction

  // Receiver: random stall pattern, plus one long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready = 1'b0;
        repeat (2000) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 99) < 3) stall = $urandom_range(1, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(stats_t'(m_axis_tdata));
  end

  initial begin
    logic [15:0] directed[$] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                                 16'h7FFF, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h0000,
                                 16'hFFFF, 16'h00FF, 16'hFF00, 16'h1234};
    int sent;
    int burst;
    int mode;
    logic [15:0] center;
    sb = new();
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_sample(directed[i]);
    // Drain completely before carrying on.
    idle_cycles(1);
    while (sb.pending_stats.size() != 0) @(negedge clk_i);

    hold_off_req = 1'b1;
    sent = 0;
    center = 16'($urandom);
    while (sent < 1650) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) center = 16'($urandom);
      mode = $urandom_range(0, 4);
      repeat (burst) begin
        send_sample(random_sample(mode, center));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 300));
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending_stats.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: running_mean_stddev_stats_core.f
+incdir+design
design/rmss_pkg.sv
design/running_mean_stddev_stats_core.sv
tb/tb_running_mean_stddev_stats_core.sv
